[hdl/crvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coupled rail voltage stepper package
// Widths, register indexes, sequencer states and the command word layout.
// ----------------------------------------------------------------------------
package crvs_pkg;

   localparam int VOLT_BITS = 21;
   localparam int CEIL_BITS = VOLT_BITS + 1;
   localparam int ACC_BITS  = VOLT_BITS + 3;
   localparam int CSR_BITS  = 3;
   localparam int CNT_BITS  = 2;

   localparam logic [CSR_BITS-1:0] REG_BIAS_MIN   = 3'd0;
   localparam logic [CSR_BITS-1:0] REG_BIAS_MAX   = 3'd1;
   localparam logic [CSR_BITS-1:0] REG_CORE_MIN   = 3'd2;
   localparam logic [CSR_BITS-1:0] REG_CORE_MAX   = 3'd3;
   localparam logic [CSR_BITS-1:0] REG_MEM_MIN    = 3'd4;
   localparam logic [CSR_BITS-1:0] REG_MEM_MAX    = 3'd5;
   localparam logic [CSR_BITS-1:0] REG_TOLERANCE  = 3'd6;
   localparam logic [CSR_BITS-1:0] REG_RAIL_COUNT = 3'd7;

   localparam logic [CNT_BITS-1:0] RAILS_SINGLE = 2'd1;
   localparam logic [CNT_BITS-1:0] RAILS_RESET  = 2'd2;

   localparam logic RAIL_CORE = 1'b0;
   localparam logic RAIL_MEM  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_TOP,
      ST_CORE_A,
      ST_CORE_B,
      ST_CORE_LO,
      ST_CORE_HI,
      ST_CORE_EMIT,
      ST_MEM_A,
      ST_MEM_B,
      ST_MEM_LO,
      ST_MEM_HI,
      ST_MEM_EMIT,
      ST_PROG,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 rail;
      logic [VOLT_BITS-1:0] set_uv;
      logic [CEIL_BITS-1:0] ceiling_uv;
      logic                 clamped;
   } cmd_type;

endpackage

[hdl/coupled_rail_voltage_stepper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coupled rail voltage stepper
// Steps a core rail and a memory rail toward a target pair in leapfrog rounds
// that keep the rail offset inside the bias window, one set command per move.
// ----------------------------------------------------------------------------
// The direction check is made in the cycle after a request is accepted; each leapfrog
// round then runs on the shared add/compare unit, with waits whenever a command word
// is held for rsp_tready; a run lasts at most MAX_ROUNDS rounds.
// Throughput: one request at a time; req_tready is high only when idle.
// A command word leaves as soon as the next one is produced or the run ends.
// Reset clears the rail levels and registers to zero and rail_count to two.
module coupled_rail_voltage_stepper
   import crvs_pkg::*;
#(
   parameter int MAX_ROUNDS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [47:0]          req_tdata,  // target_core_uv, target_mem_uv, zero fill
   input  logic                 req_tuser,  // raise
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,  // set_uv, ceiling_uv, clamped, stalled, zero fill
   output logic                 rsp_tuser,  // rail
   output logic                 rsp_tlast,
   input  logic                 csr_we,
   input  logic [CSR_BITS-1:0]  csr_addr,
   input  logic [VOLT_BITS-1:0] csr_wdata
);

   localparam int RND_BITS = $clog2(MAX_ROUNDS + 1);

   state_type state_ff, state_in;

   logic [VOLT_BITS-1:0] bias_min_ff, bias_max_ff, core_min_ff, core_max_ff;
   logic [VOLT_BITS-1:0] mem_min_ff, mem_max_ff, tol_ff;
   logic [CNT_BITS-1:0]  rails_ff;

   logic [VOLT_BITS-1:0] core_lvl_ff, core_lvl_in, mem_lvl_ff, mem_lvl_in;
   logic [VOLT_BITS-1:0] tc_ff, tc_in, tm_ff, tm_in;
   logic                 up_ff, up_in;
   logic [VOLT_BITS-1:0] s0_ff, s0_in, s1_ff, s1_in, p0_ff, p0_in, p1_ff, p1_in;
   logic [ACC_BITS-1:0]  t_ff, t_in;
   logic                 cl_ff, cl_in, single_ff, single_in, stall_ff, stall_in;
   logic [RND_BITS-1:0]  rnd_ff, rnd_in;

   cmd_type pend_ff, pend_in;
   logic    pend_valid_ff, pend_valid_in;
   cmd_type rsp_cmd_ff, rsp_cmd_in;
   logic    rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in, rsp_stall_ff, rsp_stall_in;

   logic [ACC_BITS-1:0] op_a, op_b, res;
   logic                op_sub, res_neg, res_zero, out_free, push_ok;

   // Shared add/subtract unit with sign and zero flags.
   assign res      = op_sub ? op_a - op_b : op_a + op_b;
   assign res_neg  = res[ACC_BITS-1];
   assign res_zero = (res == '0);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign push_ok  = !pend_valid_ff || out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_cmd_ff.rail;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {3'b000, rsp_stall_ff, rsp_cmd_ff.clamped,
                        rsp_cmd_ff.ceiling_uv, rsp_cmd_ff.set_uv};

   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b1;
      unique case (state_ff)
         ST_START: begin
            op_a = ACC_BITS'(core_lvl_ff);
            op_b = ACC_BITS'(tc_ff);
         end
         ST_CORE_A: begin
            op_a = ACC_BITS'(s1_ff);
            op_b = ACC_BITS'(up_ff ? bias_min_ff : bias_max_ff);
         end
         ST_CORE_B: begin
            op_a = t_ff;
            op_b = ACC_BITS'(tc_ff);
         end
         ST_CORE_LO: begin
            op_a = ACC_BITS'(s0_ff);
            op_b = ACC_BITS'(core_min_ff);
         end
         ST_CORE_HI: begin
            op_a = ACC_BITS'(core_max_ff);
            op_b = ACC_BITS'(s0_ff);
         end
         ST_CORE_EMIT: begin
            op_a   = ACC_BITS'(s0_ff);
            op_b   = ACC_BITS'(tol_ff);
            op_sub = 1'b0;
         end
         ST_MEM_A: begin
            op_a   = ACC_BITS'(s0_ff);
            op_b   = ACC_BITS'(up_ff ? bias_max_ff : bias_min_ff);
            op_sub = 1'b0;
         end
         ST_MEM_B: begin
            op_a = t_ff;
            op_b = ACC_BITS'(tm_ff);
         end
         ST_MEM_LO: begin
            op_a = ACC_BITS'(s1_ff);
            op_b = ACC_BITS'(mem_min_ff);
         end
         ST_MEM_HI: begin
            op_a = ACC_BITS'(mem_max_ff);
            op_b = ACC_BITS'(s1_ff);
         end
         ST_MEM_EMIT: begin
            op_a   = ACC_BITS'(s1_ff);
            op_b   = ACC_BITS'(tol_ff);
            op_sub = 1'b0;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if ((up_ff && !res_neg && !res_zero) || (!up_ff && res_neg)) begin
               state_in = ST_IDLE;
            end else if (rails_ff == RAILS_SINGLE) begin
               state_in = ST_CORE_EMIT;
            end else begin
               state_in = ST_TOP;
            end
         end
         ST_TOP: begin
            if ((s0_ff == tc_ff && s1_ff == tm_ff) || rnd_ff == RND_BITS'(MAX_ROUNDS)) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_CORE_A;
            end
         end
         ST_CORE_A: state_in = ST_CORE_B;
         ST_CORE_B: state_in = ST_MEM_A;
         ST_MEM_A: state_in = ST_MEM_B;
         ST_MEM_B: state_in = ST_CORE_LO;
         ST_CORE_LO: begin
            if (core_lvl_ff == s0_ff) begin
               state_in = ST_MEM_LO;
            end else if (core_max_ff == '0) begin
               state_in = ST_CORE_EMIT;
            end else begin
               state_in = ST_CORE_HI;
            end
         end
         ST_CORE_HI: state_in = ST_CORE_EMIT;
         ST_CORE_EMIT: begin
            if (push_ok) begin
               state_in = single_ff ? ST_FINISH : ST_MEM_LO;
            end
         end
         ST_MEM_LO: begin
            if (mem_lvl_ff == s1_ff) begin
               state_in = ST_PROG;
            end else if (mem_max_ff == '0) begin
               state_in = ST_MEM_EMIT;
            end else begin
               state_in = ST_MEM_HI;
            end
         end
         ST_MEM_HI: state_in = ST_MEM_EMIT;
         ST_MEM_EMIT: begin
            if (push_ok) begin
               state_in = ST_PROG;
            end
         end
         ST_PROG: begin
            state_in = (s0_ff == p0_ff && s1_ff == p1_ff) ? ST_FINISH : ST_TOP;
         end
         ST_FINISH: begin
            if (push_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      core_lvl_in   = core_lvl_ff;
      mem_lvl_in    = mem_lvl_ff;
      tc_in         = tc_ff;
      tm_in         = tm_ff;
      up_in         = up_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      p0_in         = p0_ff;
      p1_in         = p1_ff;
      t_in          = t_ff;
      cl_in         = cl_ff;
      single_in     = single_ff;
      stall_in      = stall_ff;
      rnd_in        = rnd_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_stall_in  = rsp_stall_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            tc_in = req_tdata[VOLT_BITS-1:0];
            tm_in = req_tdata[2*VOLT_BITS-1:VOLT_BITS];
            up_in = req_tuser;
         end
         ST_START: begin
            s0_in     = (rails_ff == RAILS_SINGLE) ? tc_ff : core_lvl_ff;
            s1_in     = mem_lvl_ff;
            cl_in     = 1'b0;
            single_in = (rails_ff == RAILS_SINGLE);
            stall_in  = 1'b0;
            rnd_in    = '0;
         end
         ST_TOP: begin
            if (!(s0_ff == tc_ff && s1_ff == tm_ff)) begin
               if (rnd_ff == RND_BITS'(MAX_ROUNDS)) begin
                  stall_in = 1'b1;
               end else begin
                  rnd_in = rnd_ff + 1'b1;
                  p0_in  = s0_ff;
                  p1_in  = s1_ff;
               end
            end
         end
         ST_CORE_A, ST_MEM_A: begin
            t_in = res;
         end
         ST_CORE_B: begin
            if (up_ff) begin
               if (!res_neg && !res_zero) begin
                  s0_in = tc_ff;
               end else if (t_ff[ACC_BITS-1]) begin
                  s0_in = '0;
               end else begin
                  s0_in = t_ff[VOLT_BITS-1:0];
               end
            end else begin
               s0_in = res_neg ? tc_ff : t_ff[VOLT_BITS-1:0];
            end
         end
         ST_MEM_B: begin
            if (up_ff) begin
               s1_in = (!res_neg && !res_zero) ? tm_ff : t_ff[VOLT_BITS-1:0];
            end else if (res_neg) begin
               s1_in = tm_ff;
            end else if (t_ff[ACC_BITS-1:VOLT_BITS] != '0) begin
               s1_in = '1;
            end else begin
               s1_in = t_ff[VOLT_BITS-1:0];
            end
         end
         ST_CORE_LO: begin
            cl_in = (core_max_ff != '0) && res_neg;
            if (core_lvl_ff != s0_ff && core_max_ff != '0 && res_neg) begin
               s0_in = core_min_ff;
            end
         end
         ST_MEM_LO: begin
            cl_in = (mem_max_ff != '0) && res_neg;
            if (mem_lvl_ff != s1_ff && mem_max_ff != '0 && res_neg) begin
               s1_in = mem_min_ff;
            end
         end
         ST_CORE_HI: begin
            if (res_neg) begin
               s0_in = core_max_ff;
               cl_in = 1'b1;
            end
         end
         ST_MEM_HI: begin
            if (res_neg) begin
               s1_in = mem_max_ff;
               cl_in = 1'b1;
            end
         end
         ST_CORE_EMIT, ST_MEM_EMIT: begin
            if (push_ok) begin
               if (pend_valid_ff) begin
                  rsp_cmd_in   = pend_ff;
                  rsp_last_in  = 1'b0;
                  rsp_stall_in = 1'b0;
                  rsp_valid_in = 1'b1;
               end
               pend_valid_in      = 1'b1;
               pend_in.ceiling_uv = res[CEIL_BITS-1:0];
               pend_in.clamped    = cl_ff;
               if (state_ff == ST_CORE_EMIT) begin
                  pend_in.rail   = RAIL_CORE;
                  pend_in.set_uv = s0_ff;
                  core_lvl_in    = s0_ff;
               end else begin
                  pend_in.rail   = RAIL_MEM;
                  pend_in.set_uv = s1_ff;
                  mem_lvl_in     = s1_ff;
               end
            end
         end
         ST_PROG: begin
            if (s0_ff == p0_ff && s1_ff == p1_ff) begin
               stall_in = 1'b1;
            end
         end
         ST_FINISH: begin
            if (pend_valid_ff && out_free) begin
               rsp_cmd_in    = pend_ff;
               rsp_last_in   = 1'b1;
               rsp_stall_in  = stall_ff;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            t_in = t_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bias_min_ff   <= '0;
         bias_max_ff   <= '0;
         core_min_ff   <= '0;
         core_max_ff   <= '0;
         mem_min_ff    <= '0;
         mem_max_ff    <= '0;
         tol_ff        <= '0;
         rails_ff      <= RAILS_RESET;
         core_lvl_ff   <= '0;
         mem_lvl_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rnd_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         core_lvl_ff   <= core_lvl_in;
         mem_lvl_ff    <= mem_lvl_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rnd_ff        <= rnd_in;
         if (csr_we) begin
            unique case (csr_addr)
               REG_BIAS_MIN:   bias_min_ff <= csr_wdata;
               REG_BIAS_MAX:   bias_max_ff <= csr_wdata;
               REG_CORE_MIN:   core_min_ff <= csr_wdata;
               REG_CORE_MAX:   core_max_ff <= csr_wdata;
               REG_MEM_MIN:    mem_min_ff  <= csr_wdata;
               REG_MEM_MAX:    mem_max_ff  <= csr_wdata;
               REG_TOLERANCE:  tol_ff      <= csr_wdata;
               REG_RAIL_COUNT: rails_ff    <= csr_wdata[CNT_BITS-1:0];
               default:        tol_ff      <= tol_ff;
            endcase
         end
      end
      tc_ff        <= tc_in;
      tm_ff        <= tm_in;
      up_ff        <= up_in;
      s0_ff        <= s0_in;
      s1_ff        <= s1_in;
      p0_ff        <= p0_in;
      p1_ff        <= p1_in;
      t_ff         <= t_in;
      cl_ff        <= cl_in;
      single_ff    <= single_in;
      stall_ff     <= stall_in;
      pend_ff      <= pend_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_stall_ff <= rsp_stall_in;
   end

`ifndef SYNTHESIS
   a_idle_empty : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held command word left over after a run");

   a_round_limit : assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= RND_BITS'(MAX_ROUNDS))
      else $error("round counter passed its limit");

   a_stall_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall_ff |-> rsp_last_ff)
      else $error("stalled flag on a word that does not end the run");

   a_push_on_finish : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && state_in == ST_IDLE && pend_valid_ff |=>
      rsp_valid_ff && rsp_last_ff)
      else $error("final word of a run was not delivered");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coupled rail voltage stepper testbench
// Drives rail voltage requests through directed cases and random traffic under
// many register settings, predicts every set command from a local model of the
// rail levels and checks each result word as it arrives, with random stalls.
// ----------------------------------------------------------------------------
module tb;
   import crvs_pkg::*;

   localparam int MAX_ROUNDS = 32;
   localparam int DRAIN_CYCLES = MAX_ROUNDS * 12 + 16;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam longint VOLT_MAX = (longint'(1) << VOLT_BITS) - 1;
   localparam logic [CNT_BITS-1:0] RAILS_NONE = 2'd0;
   localparam logic [CNT_BITS-1:0] RAILS_ODD = 2'd3;

   typedef struct packed {
      logic                 rail;
      logic [VOLT_BITS-1:0] set_uv;
      logic [CEIL_BITS-1:0] ceiling_uv;
      logic                 clamped;
      logic                 stalled;
      logic                 last;
   } rail_cmd_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [47:0]          req_tdata = '0;  // target_core_uv, target_mem_uv, zero fill
   logic                 req_tuser = 1'b0;  // raise
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [47:0]          rsp_tdata;  // set_uv, ceiling_uv, clamped, stalled, zero fill
   logic                 rsp_tuser;  // rail
   logic                 rsp_tlast;
   logic                 csr_we = 1'b0;
   logic [CSR_BITS-1:0]  csr_addr = REG_BIAS_MIN;
   logic [VOLT_BITS-1:0] csr_wdata = '0;

   coupled_rail_voltage_stepper #(.MAX_ROUNDS(MAX_ROUNDS)) dut (.*);

   logic [VOLT_BITS-1:0] reg_bias_min = '0, reg_bias_max = '0;
   logic [VOLT_BITS-1:0] reg_core_min = '0, reg_core_max = '0;
   logic [VOLT_BITS-1:0] reg_mem_min = '0, reg_mem_max = '0;
   logic [VOLT_BITS-1:0] reg_tolerance = '0;
   logic [CNT_BITS-1:0]  reg_rails = RAILS_RESET;
   logic [VOLT_BITS-1:0] lvl_core = '0, lvl_mem = '0;

   rail_cmd_type run_cmds[$];
   rail_cmd_type pending_cmds[$];

   bit          idling_on = 1'b1;
   int unsigned rsp_hold = 0;
   int unsigned cycle_count = 0;
   int          mismatches = 0;
   int          requests_sent = 0;
   int          settings_used = 0;
   int          results_seen = 0;
   int          stalled_seen = 0;
   int          clamped_seen = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("coupled_rail_voltage_stepper test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_tready <= 1'b1;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= $urandom_range(0, 7);
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold <= $urandom_range(0, 7);
      end
   end

   function automatic longint clip_volt(input longint v);
      if (v < 0) return 0;
      if (v > VOLT_MAX) return VOLT_MAX;
      return v;
   endfunction

   // Clamps a changed rail to its limits, records the command and the new level.
   function automatic void move_rail(input logic rail, inout longint step,
                                     inout logic [VOLT_BITS-1:0] level,
                                     input longint lo, input longint hi);
      rail_cmd_type cmd;
      cmd = '0;
      if (longint'(level) == step) return;
      if (hi > 0 && (step < lo || step > hi)) begin
         cmd.clamped = 1'b1;
         if (step < lo) step = lo;
         if (step > hi) step = hi;
      end
      cmd.rail = rail;
      cmd.set_uv = step[VOLT_BITS-1:0];
      cmd.ceiling_uv = {1'b0, step[VOLT_BITS-1:0]} + {1'b0, reg_tolerance};
      run_cmds.push_back(cmd);
      level = step[VOLT_BITS-1:0];
   endfunction

   function automatic void predict_commands(input longint tc, input longint tm,
                                            input logic up);
      longint       s0, s1, p0, p1, a, bmin, bmax;
      int           rounds, n;
      bit           stall, done;
      rail_cmd_type cmd;
      run_cmds.delete();
      bmin = reg_bias_min;
      bmax = reg_bias_max;
      if ((up && longint'(lvl_core) > tc) || (!up && longint'(lvl_core) < tc)) return;
      if (reg_rails == RAILS_SINGLE) begin
         cmd = '0;
         cmd.rail = RAIL_CORE;
         cmd.set_uv = tc[VOLT_BITS-1:0];
         cmd.ceiling_uv = {1'b0, tc[VOLT_BITS-1:0]} + {1'b0, reg_tolerance};
         cmd.last = 1'b1;
         pending_cmds.push_back(cmd);
         lvl_core = tc[VOLT_BITS-1:0];
         return;
      end
      s0 = lvl_core;
      s1 = lvl_mem;
      rounds = 0;
      stall = 1'b0;
      done = 1'b0;
      while (!done) begin
         if (s0 == tc && s1 == tm) begin
            done = 1'b1;
         end else if (rounds >= MAX_ROUNDS) begin
            stall = 1'b1;
            done = 1'b1;
         end else begin
            rounds++;
            p0 = s0;
            p1 = s1;
            if (up) begin
               a = s1 - bmin;
               if (a > tc) a = tc;
               s0 = clip_volt(a);
               a = s0 + bmax;
               if (a > tm) a = tm;
               s1 = clip_volt(a);
            end else begin
               a = s1 - bmax;
               if (a < tc) a = tc;
               s0 = clip_volt(a);
               a = s0 + bmin;
               if (a < tm) a = tm;
               s1 = clip_volt(a);
            end
            move_rail(RAIL_CORE, s0, lvl_core, reg_core_min, reg_core_max);
            move_rail(RAIL_MEM, s1, lvl_mem, reg_mem_min, reg_mem_max);
            if (s0 == p0 && s1 == p1) begin
               stall = 1'b1;
               done = 1'b1;
            end
         end
      end
      n = run_cmds.size();
      if (n > 0) begin
         cmd = run_cmds[n-1];
         cmd.stalled = stall;
         cmd.last = 1'b1;
         run_cmds[n-1] = cmd;
      end
      foreach (run_cmds[i]) pending_cmds.push_back(run_cmds[i]);
   endfunction

   task automatic check_command();
      rail_cmd_type got, want;
      got.rail = rsp_tuser;
      got.set_uv = rsp_tdata[20:0];
      got.ceiling_uv = rsp_tdata[42:21];
      got.clamped = rsp_tdata[43];
      got.stalled = rsp_tdata[44];
      got.last = rsp_tlast;
      results_seen++;
      stalled_seen += got.stalled;
      clamped_seen += got.clamped;
      if (pending_cmds.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected word: rail %0d set %0d ceil %0d cl %0d st %0d last %0d",
                     got.rail, got.set_uv, got.ceiling_uv, got.clamped, got.stalled,
                     got.last);
      end else begin
         want = pending_cmds.pop_front();
         if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch at word %0d:", results_seen);
               $display("  want rail %0d set %0d ceil %0d cl %0d st %0d last %0d",
                        want.rail, want.set_uv, want.ceiling_uv, want.clamped,
                        want.stalled, want.last);
               $display("  got  rail %0d set %0d ceil %0d cl %0d st %0d last %0d",
                        got.rail, got.set_uv, got.ceiling_uv, got.clamped,
                        got.stalled, got.last);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_command();
   end

   task automatic send_request(input logic [VOLT_BITS-1:0] tc,
                               input logic [VOLT_BITS-1:0] tm, input logic up);
      @(posedge clock);
      if (idling_on && $urandom_range(0, 1) == 1)
         repeat ($urandom_range(1, 8)) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {6'b0, tm, tc};
      req_tuser <= up;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
      predict_commands(tc, tm, up);
      requests_sent++;
   endtask

   task automatic settle();
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_BITS-1:0] idx,
                            input logic [VOLT_BITS-1:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_BIAS_MIN:   reg_bias_min = val;
         REG_BIAS_MAX:   reg_bias_max = val;
         REG_CORE_MIN:   reg_core_min = val;
         REG_CORE_MAX:   reg_core_max = val;
         REG_MEM_MIN:    reg_mem_min = val;
         REG_MEM_MAX:    reg_mem_max = val;
         REG_TOLERANCE:  reg_tolerance = val;
         REG_RAIL_COUNT: reg_rails = val[CNT_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [VOLT_BITS-1:0] bmin, bmax, cmin, cmax,
                                input logic [VOLT_BITS-1:0] mmin, mmax, tol,
                                input logic [CNT_BITS-1:0] rails);
      settle();
      write_reg(REG_BIAS_MIN, bmin);
      write_reg(REG_BIAS_MAX, bmax);
      write_reg(REG_CORE_MIN, cmin);
      write_reg(REG_CORE_MAX, cmax);
      write_reg(REG_MEM_MIN, mmin);
      write_reg(REG_MEM_MAX, mmax);
      write_reg(REG_TOLERANCE, tol);
      write_reg(REG_RAIL_COUNT, {{(VOLT_BITS-CNT_BITS){1'b0}}, rails});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic test_reset_state();
      send_request(21'd1000, 21'd1000, 1'b1);
      send_request(21'd0, 21'd0, 1'b1);
   endtask

   task automatic test_coupled_moves();
      apply_setting(0, 100000, 0, 0, 0, 0, 50000, RAILS_RESET);
      send_request(21'd600000, 21'd650000, 1'b1);
      send_request(21'd100000, 21'd100000, 1'b1);
      send_request(21'd200000, 21'd250000, 1'b0);
      send_request(21'd200000, 21'd250000, 1'b0);
      send_request(21'd300000, 21'd300000, 1'b0);
   endtask

   task automatic test_round_limit();
      apply_setting(0, 1000, 0, 0, 0, 0, 0, RAILS_RESET);
      send_request(21'd1500000, 21'd1500000, 1'b1);
      send_request(21'd100000, 21'd100000, 1'b0);
   endtask

   task automatic test_rail_limits();
      apply_setting(0, 200000, 100000, 400000, 150000, 500000, 21'h1FFFFF, RAILS_RESET);
      send_request(21'd900000, 21'd950000, 1'b1);
      send_request(21'd0, 21'd0, 1'b0);
      // Minimum above maximum on both rails.
      apply_setting(0, 200000, 800000, 300000, 900000, 400000, 1000, RAILS_RESET);
      send_request(21'h1FFFFF, 21'h1FFFFF, 1'b1);
      send_request(21'd0, 21'd0, 1'b0);
   endtask

   task automatic test_saturation();
      apply_setting(0, 21'h1FFFFF, 0, 0, 0, 0, 21'h1FFFFF, RAILS_RESET);
      send_request(21'd2000000, 21'h1FFFFF, 1'b1);
      apply_setting(21'h1FFFFF, 21'h1FFFFF, 0, 0, 0, 0, 21'h1FFFFF, RAILS_RESET);
      send_request(21'd1900000, 21'd0, 1'b0);
      send_request(21'h1FFFFF, 21'h1FFFFF, 1'b1);
   endtask

   task automatic test_single_rail();
      apply_setting(0, 0, 0, 0, 0, 0, 21'h1FFFFF, RAILS_SINGLE);
      send_request(21'h1FFFFF, 21'd0, 1'b1);
      send_request(21'h1FFFFF, 21'd1234, 1'b1);
      send_request(21'd5, 21'd0, 1'b1);
      send_request(21'd0, 21'h1FFFFF, 1'b0);
   endtask

   task automatic test_odd_rail_counts();
      apply_setting(50000, 150000, 0, 0, 0, 0, 100, RAILS_NONE);
      send_request(21'd500000, 21'd600000, 1'b1);
      apply_setting(50000, 150000, 0, 0, 0, 0, 100, RAILS_ODD);
      send_request(21'd300000, 21'd400000, 1'b0);
   endtask

   task automatic random_setting();
      logic [VOLT_BITS-1:0] bmin, bmax, cmin, cmax, mmin, mmax, tol;
      logic [CNT_BITS-1:0]  rails;
      int unsigned          pick;
      bmin = VOLT_BITS'($urandom_range(0, 150000));
      if ($urandom_range(0, 5) == 0) bmax = VOLT_BITS'($urandom_range(0, bmin));
      else bmax = VOLT_BITS'(bmin + $urandom_range(1000, 300000));
      cmin = VOLT_BITS'($urandom_range(0, 500000));
      cmax = ($urandom_range(0, 2) == 0) ? '0 :
             VOLT_BITS'(cmin + $urandom_range(200000, 1500000));
      mmin = VOLT_BITS'($urandom_range(0, 500000));
      mmax = ($urandom_range(0, 2) == 0) ? '0 :
             VOLT_BITS'(mmin + $urandom_range(200000, 1500000));
      tol = VOLT_BITS'($urandom_range(0, 300000));
      pick = $urandom_range(0, 7);
      case (pick)
         0: rails = RAILS_SINGLE;
         1: rails = RAILS_NONE;
         2: rails = RAILS_ODD;
         default: rails = RAILS_RESET;
      endcase
      apply_setting(bmin, bmax, cmin, cmax, mmin, mmax, tol, rails);
   endtask

   // Mostly requests that head the right way from the present core level, with
   // a memory target inside the bias window; some wrong-way and raw words.
   task automatic random_request();
      logic [VOLT_BITS-1:0] tc, tm;
      logic                 up;
      longint               off;
      int unsigned          kind;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         tc = VOLT_BITS'($urandom);
         tm = VOLT_BITS'($urandom);
         up = 1'($urandom_range(0, 1));
      end else begin
         tc = VOLT_BITS'($urandom_range(150000, 1600000));
         if (reg_bias_max >= reg_bias_min) off = $urandom_range(reg_bias_min, reg_bias_max);
         else off = $urandom_range(0, 300000);
         tm = VOLT_BITS'((longint'(tc) + off > VOLT_MAX) ? VOLT_MAX : longint'(tc) + off);
         up = (tc > lvl_core) || (tc == lvl_core && $urandom_range(0, 1) == 1);
         if (kind == 1 && tc != lvl_core) up = !up;
      end
      send_request(tc, tm, up);
   endtask

   task automatic test_random_traffic(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         if (p == phases - 1) idling_on <= 1'b0;
         random_setting();
         repeat (per_phase) random_request();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_coupled_moves();
      test_round_limit();
      test_rail_limits();
      test_saturation();
      test_single_rail();
      test_odd_rail_counts();
      test_random_traffic(6, 42);
      settle();
      $display("Sent %0d voltage requests under %0d register settings.",
               requests_sent, settings_used);
      $display("Checked %0d set command words, %0d stalled and %0d clamped.",
               results_seen, stalled_seen, clamped_seen);
      if (mismatches == 0 && pending_cmds.size() == 0) begin
         $display("coupled_rail_voltage_stepper test passed");
      end else begin
         $display("coupled_rail_voltage_stepper test failed");
      end
      $finish;
   end

endmodule
